FILE: hdl/spc_pkg.sv
// Shared types, constants and coil sequence tables for the stepper position controller.
package spc_pkg;

	localparam int DEG_PER_REV = 360;
	localparam int GOAL_W      = 10;
	localparam int POS_W       = 16;
	localparam int ANGLE_W     = 11;
	localparam int COIL_W      = 4;
	localparam int PHASE_W     = 2;
	localparam int DEG_W       = 9;

	typedef enum logic {
		OP_TICK       = 1'b0,
		OP_SET_TARGET = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	typedef struct packed {
		logic signed [POS_W-1:0]   pos;
		logic [GOAL_W-1:0]         goal;
		logic [PHASE_W-1:0]        phase;
		dir_t                      dir;
		logic                      home;
		logic [COIL_W-1:0]         coil;
	} state_t;

	function automatic logic [COIL_W-1:0] cw_pattern(input logic [PHASE_W-1:0] phase);
		logic [COIL_W-1:0] pat;
		unique case (phase)
			2'd0: pat = 4'd3;
			2'd1: pat = 4'd6;
			2'd2: pat = 4'd12;
			default: pat = 4'd9;
		endcase
		return pat;
	endfunction

	function automatic logic [COIL_W-1:0] ccw_pattern(input logic [PHASE_W-1:0] phase);
		logic [COIL_W-1:0] pat;
		unique case (phase)
			2'd0: pat = 4'd12;
			2'd1: pat = 4'd6;
			2'd2: pat = 4'd3;
			default: pat = 4'd9;
		endcase
		return pat;
	endfunction

endpackage

FILE: hdl/spc_target_scale.sv
// Angle front end: floored modulo 360 of the request angle and scaling by steps per revolution.
module spc_target_scale #(
	parameter int STEPS_PER_REV = 512,
	parameter int PROD_W        = 19
) (
	input  logic signed [spc_pkg::ANGLE_W-1:0] target_angle,
	output logic [PROD_W-1:0]                  scaled
);

	localparam int U_W = spc_pkg::ANGLE_W + 1;

	logic [U_W-1:0]            shifted;
	logic [U_W-1:0]            reduced;
	logic [spc_pkg::DEG_W-1:0] degrees;

	// Adding three turns makes every input angle non-negative without changing it modulo 360.
	assign shifted = U_W'({target_angle[spc_pkg::ANGLE_W-1], target_angle})
		+ U_W'(3 * spc_pkg::DEG_PER_REV);

	always_comb begin
		if (shifted >= U_W'(5 * spc_pkg::DEG_PER_REV)) begin
			reduced = shifted - U_W'(5 * spc_pkg::DEG_PER_REV);
		end else if (shifted >= U_W'(4 * spc_pkg::DEG_PER_REV)) begin
			reduced = shifted - U_W'(4 * spc_pkg::DEG_PER_REV);
		end else if (shifted >= U_W'(3 * spc_pkg::DEG_PER_REV)) begin
			reduced = shifted - U_W'(3 * spc_pkg::DEG_PER_REV);
		end else if (shifted >= U_W'(2 * spc_pkg::DEG_PER_REV)) begin
			reduced = shifted - U_W'(2 * spc_pkg::DEG_PER_REV);
		end else if (shifted >= U_W'(spc_pkg::DEG_PER_REV)) begin
			reduced = shifted - U_W'(spc_pkg::DEG_PER_REV);
		end else begin
			reduced = shifted;
		end
	end

	assign degrees = reduced[spc_pkg::DEG_W-1:0];
	assign scaled  = PROD_W'(degrees) * PROD_W'(STEPS_PER_REV);

endmodule

FILE: hdl/spc_motion_core.sv
// Next-state logic: target division, homing, step sequencing and position counting.
module spc_motion_core #(
	parameter int PROD_W        = 19
) (
	input  spc_pkg::state_t    cur,
	input  spc_pkg::op_t       op,
	input  logic               home_sensor,
	input  logic [PROD_W-1:0]  scaled,
	output spc_pkg::state_t    nxt
);

	// Division by 360 is a multiply by a rounded-up reciprocal; the shift keeps the error below one.
	localparam int     SHIFT   = PROD_W + 9;
	localparam int     RECIP_W = SHIFT - 7;
	localparam longint RECIP   = ((64'd1 << SHIFT) + 64'(spc_pkg::DEG_PER_REV - 1))
		/ 64'(spc_pkg::DEG_PER_REV);
	localparam int     FULL_W  = PROD_W + RECIP_W;

	logic [FULL_W-1:0]                 full;
	logic [spc_pkg::GOAL_W-1:0]        goal_new;
	logic signed [spc_pkg::POS_W-1:0]  goal_ext;
	logic                              play;
	spc_pkg::dir_t                     play_dir;
	logic [spc_pkg::PHASE_W-1:0]       play_phase;

	assign full     = FULL_W'(scaled) * FULL_W'(RECIP_W'(RECIP));
	assign goal_new = full[SHIFT +: spc_pkg::GOAL_W];
	assign goal_ext = spc_pkg::POS_W'(cur.goal);

	always_comb begin
		nxt        = cur;
		play       = 1'b0;
		play_dir   = cur.dir;
		play_phase = cur.phase;
		if (op == spc_pkg::OP_SET_TARGET) begin
			nxt.goal = goal_new;
		end else begin
			if (cur.phase != '0
				&& (cur.dir == spc_pkg::DIR_CW || cur.dir == spc_pkg::DIR_CCW)) begin
				// A step in progress always finishes its four patterns.
				play = 1'b1;
			end else begin
				nxt.phase  = '0;
				play_phase = '0;
				if (cur.home) begin
					if (home_sensor) begin
						nxt.pos  = '0;
						nxt.home = 1'b0;
						nxt.dir  = spc_pkg::DIR_IDLE;
					end else begin
						play     = 1'b1;
						play_dir = spc_pkg::DIR_CW;
					end
				end else if (cur.pos == goal_ext) begin
					nxt.coil = '0;
					nxt.dir  = spc_pkg::DIR_IDLE;
				end else begin
					play     = 1'b1;
					play_dir = (goal_ext > cur.pos) ? spc_pkg::DIR_CCW : spc_pkg::DIR_CW;
				end
			end

			if (play) begin
				nxt.dir  = play_dir;
				nxt.coil = (play_dir == spc_pkg::DIR_CW) ? spc_pkg::cw_pattern(play_phase)
					: spc_pkg::ccw_pattern(play_phase);
				if (play_phase == '1) begin
					if (play_dir == spc_pkg::DIR_CW) begin
						if (cur.pos != {1'b1, {(spc_pkg::POS_W-1){1'b0}}}) begin
							nxt.pos = cur.pos - 16'sd1;
						end
					end else begin
						if (cur.pos != {1'b0, {(spc_pkg::POS_W-1){1'b1}}}) begin
							nxt.pos = cur.pos + 16'sd1;
						end
					end
					nxt.phase = '0;
					nxt.dir   = spc_pkg::DIR_IDLE;
				end else begin
					nxt.phase = play_phase + 2'd1;
				end
			end
		end
	end

endmodule

FILE: hdl/stepper_position_controller.sv
// The result register loads from the input stage once a request there meets a free output.
// Throughput: one request per cycle while the output is not stalled; the controller state
// updates with the result register, so each request sees the state left by the one before it.
// Reset: asynchronous, active low; homing starts, position, target and state coils are zero.
// The result register holds while stalled and the input stage keeps taking requests until full.
module stepper_position_controller #(
	parameter int STEPS_PER_REV = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [0:0]                         operation,
	input  logic                               home_sensor,
	input  logic signed [spc_pkg::ANGLE_W-1:0] target_angle,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [spc_pkg::COIL_W-1:0]         coil_pattern,
	output logic signed [spc_pkg::POS_W-1:0]   position,
	output logic                               at_target,
	output logic                               homing
);

	localparam int PROD_W = $clog2((spc_pkg::DEG_PER_REV - 1) * STEPS_PER_REV + 1);

	logic               valid_s1;
	spc_pkg::op_t       op_s1;
	logic               sensor_s1;
	logic [PROD_W-1:0]  scaled_s1;
	logic [PROD_W-1:0]  scaled;
	logic               out_valid_q;
	logic               out_free;
	logic               advance;
	logic               in_accept;
	spc_pkg::state_t    state_q;
	spc_pkg::state_t    state_nxt;
	logic               at_target_nxt;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	spc_target_scale #(
		.STEPS_PER_REV(STEPS_PER_REV),
		.PROD_W(PROD_W)
	) u_scale (
		.target_angle(target_angle),
		.scaled(scaled)
	);

	spc_motion_core #(
		.PROD_W(PROD_W)
	) u_core (
		.cur(state_q),
		.op(op_s1),
		.home_sensor(sensor_s1),
		.scaled(scaled_s1),
		.nxt(state_nxt)
	);

	assign at_target_nxt = !state_nxt.home
		&& (state_nxt.pos == spc_pkg::POS_W'(state_nxt.goal));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1     <= spc_pkg::op_t'(operation);
			sensor_s1 <= home_sensor;
			scaled_s1 <= scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pos   <= '0;
			state_q.goal  <= '0;
			state_q.phase <= '0;
			state_q.dir   <= spc_pkg::DIR_IDLE;
			state_q.home  <= 1'b1;
			state_q.coil  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coil_pattern <= state_nxt.coil;
			position     <= state_nxt.pos;
			at_target    <= at_target_nxt;
			homing       <= state_nxt.home;
		end
	end

`ifndef SYNTHESIS
	// Once the home search has ended it never restarts.
	a_home_once: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.home |=> !state_q.home)
		else $error("home search restarted");

	// A nonzero phase only exists inside a step with a real direction.
	a_phase_dir: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase != '0 |-> (state_q.dir == spc_pkg::DIR_CW
			|| state_q.dir == spc_pkg::DIR_CCW))
		else $error("step phase without direction");

	// The input side is held off only while a request waits in the input stage.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a waiting request");

	// A result never claims to be on target while still homing.
	a_target_home: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(at_target && homing))
		else $error("on target reported during homing");
`endif

endmodule
